// ===== rtl/core/lls_pkg.sv =====
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types for the link latency statistics block: the request and result
// payloads of the external channels and the classified queue entry.
// ----------------------------------------------------------------------------
package lls_pkg;

    // input request: delivery report or timeout event
    typedef struct packed {
        logic        command;
        logic [31:0] sequence_number;
        logic        was_delivered;
        logic [31:0] latency_us;
    } report_t;

    // result: snapshot of the statistics after one request
    typedef struct packed {
        logic [31:0] sent_count;
        logic [31:0] dropped_count;
        logic [31:0] delivered_count;
        logic [31:0] timeout_count;
        logic [31:0] last_seq;
        logic [31:0] latency_min;
        logic [31:0] latency_max;
        logic [47:0] latency_mean;
        logic        stats_valid;
    } stats_t;

    // command codes of the report channel
    localparam logic CMD_REPORT  = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // operation chosen by the front end
    typedef enum logic [1:0] {
        OP_TIMEOUT = 2'd0,
        OP_DROP    = 2'd1,
        OP_DELIVER = 2'd2
    } op_t;

    // classified request held in the queue, latency already clamped
    typedef struct packed {
        op_t         op;
        logic [31:0] seq;
        logic [31:0] latency;
    } entry_t;

endpackage

// ===== rtl/core/lls_stream_if.sv =====
// ----------------------------------------------------------------------------
// lls_stream_if
// Valid/ready channel carrying one payload of a chosen type per request.
// ----------------------------------------------------------------------------
interface lls_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/lls_front.sv =====
// ----------------------------------------------------------------------------
// lls_front
// Front end: classifies each incoming request into timeout, drop or delivery
// and clamps the latency to the configured range before queueing it.
// ----------------------------------------------------------------------------
module lls_front #(
    parameter int LATENCY_BITS = 32
) (
    lls_stream_if.sink   report,
    lls_stream_if.source entry
);
    localparam int CLAMP_BITS = (LATENCY_BITS < 32) ? LATENCY_BITS : 32;
    localparam logic [31:0] LAT_LIMIT = 32'((64'(1) << CLAMP_BITS) - 64'(1));

    lls_pkg::report_t req;
    lls_pkg::entry_t  cls;

    assign req = report.payload;

    // classify and clamp
    always_comb
    begin
        cls.seq     = req.sequence_number;
        cls.latency = (req.latency_us > LAT_LIMIT) ? LAT_LIMIT : req.latency_us;
        if (req.command == lls_pkg::CMD_TIMEOUT)
        begin
            cls.op = lls_pkg::OP_TIMEOUT;
        end
        else if (req.was_delivered)
        begin
            cls.op = lls_pkg::OP_DELIVER;
        end
        else
        begin
            cls.op = lls_pkg::OP_DROP;
        end
    end

    // hand over to the queue
    assign entry.valid   = report.valid;
    assign entry.payload = cls;
    assign report.ready  = entry.ready;

endmodule

// ===== rtl/core/lls_queue.sv =====
// ----------------------------------------------------------------------------
// lls_queue
// Short first-in first-out queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module lls_queue #(
    parameter int DEPTH = 2
) (
    input logic          clk,
    input logic          rst_n,
    lls_stream_if.sink   push,
    lls_stream_if.source pop
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    lls_pkg::entry_t       store [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign push.ready  = (count_reg != CNT_BITS'(DEPTH));
    assign pop.valid   = (count_reg != '0);
    assign pop.payload = store[rd_ptr_reg];
    assign do_push     = push.valid && push.ready;
    assign do_pop      = pop.valid && pop.ready;

    // pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push.payload;
        end
    end

endmodule

// ===== rtl/core/lls_divider.sv =====
// ----------------------------------------------------------------------------
// lls_divider
// Restoring divider producing one quotient bit per cycle; the quotient
// is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module lls_divider #(
    parameter int DIVIDEND_BITS = 48,
    parameter int DIVISOR_BITS  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);
    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dsr_reg;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    reduced;
    logic                     fits;

    // one trial subtraction per cycle
    assign trial   = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign reduced = trial - {1'b0, dsr_reg};
    assign fits    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= fits ? reduced[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        end
    end

    // step counter
    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_BITS'(DIVIDEND_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/lls_back.sv =====
// ----------------------------------------------------------------------------
// lls_back
// Back end: holds the statistics, applies one queued request at a time,
// runs the mean step through the serial divider and registers the result.
// ----------------------------------------------------------------------------
module lls_back #(
    parameter int COUNT_BITS         = 32,
    parameter int LATENCY_BITS       = 32,
    parameter int MEAN_FRACTION_BITS = 16
) (
    input logic          clk,
    input logic          rst_n,
    lls_stream_if.sink   queue,
    lls_stream_if.source result
);
    localparam int MEAN_BITS = LATENCY_BITS + MEAN_FRACTION_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_BITS-1:0]   sent_reg, sent_next;
    logic [COUNT_BITS-1:0]   dropped_reg, dropped_next;
    logic [COUNT_BITS-1:0]   delivered_reg, delivered_next;
    logic [COUNT_BITS-1:0]   timeout_reg, timeout_next;
    logic [31:0]             seq_reg, seq_next;
    logic [LATENCY_BITS-1:0] min_reg, min_next;
    logic [LATENCY_BITS-1:0] max_reg, max_next;
    logic [MEAN_BITS-1:0]    mean_reg, mean_next;
    logic                    have_reg, have_next;
    logic                    down_reg, down_next;
    logic                    out_valid_reg, out_valid_next;
    lls_pkg::stats_t         out_reg, out_next;

    lls_pkg::entry_t         entry;
    logic [LATENCY_BITS-1:0] lat;
    logic [MEAN_BITS-1:0]    target;
    logic [COUNT_BITS-1:0]   delivered_inc;
    logic [MEAN_BITS-1:0]    gap;
    logic                    div_start;
    logic                    div_done;
    logic [MEAN_BITS-1:0]    div_quotient;
    logic                    slot_free;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    assign entry         = queue.payload;
    assign lat           = LATENCY_BITS'(entry.latency);
    assign target        = MEAN_BITS'(lat) << MEAN_FRACTION_BITS;
    assign delivered_inc = sat_inc(delivered_reg);
    assign gap           = (target < mean_reg) ? mean_reg - target : target - mean_reg;
    assign slot_free     = !out_valid_reg || result.ready;
    assign queue.ready   = (state_reg == ST_IDLE);

    // mean step divided by the delivered count
    lls_divider #(
        .DIVIDEND_BITS (MEAN_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (gap),
        .divisor  (delivered_inc),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // request sequencing and statistics update
    always_comb
    begin
        state_next     = state_reg;
        sent_next      = sent_reg;
        dropped_next   = dropped_reg;
        delivered_next = delivered_reg;
        timeout_next   = timeout_reg;
        seq_next       = seq_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        mean_next      = mean_reg;
        have_next      = have_reg;
        down_next      = down_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (queue.valid)
                begin
                    state_next = ST_EMIT;
                    case (entry.op)
                        lls_pkg::OP_TIMEOUT:
                        begin
                            timeout_next = sat_inc(timeout_reg);
                        end
                        lls_pkg::OP_DROP:
                        begin
                            sent_next    = sat_inc(sent_reg);
                            seq_next     = entry.seq;
                            dropped_next = sat_inc(dropped_reg);
                        end
                        lls_pkg::OP_DELIVER:
                        begin
                            sent_next      = sat_inc(sent_reg);
                            seq_next       = entry.seq;
                            delivered_next = delivered_inc;
                            if (!have_reg)
                            begin
                                min_next  = lat;
                                max_next  = lat;
                                mean_next = target;
                                have_next = 1'b1;
                            end
                            else
                            begin
                                if (lat < min_reg)
                                begin
                                    min_next = lat;
                                end
                                if (lat > max_reg)
                                begin
                                    max_next = lat;
                                end
                                down_next  = (target < mean_reg);
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = down_reg ? mean_reg - div_quotient
                                          : mean_reg + div_quotient;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_next.sent_count      = 32'(sent_reg);
                    out_next.dropped_count   = 32'(dropped_reg);
                    out_next.delivered_count = 32'(delivered_reg);
                    out_next.timeout_count   = 32'(timeout_reg);
                    out_next.last_seq        = seq_reg;
                    out_next.latency_min     = 32'(min_reg);
                    out_next.latency_max     = 32'(max_reg);
                    out_next.latency_mean    = 48'(mean_reg);
                    out_next.stats_valid     = have_reg;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sent_reg      <= '0;
            dropped_reg   <= '0;
            delivered_reg <= '0;
            timeout_reg   <= '0;
            seq_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            mean_reg      <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sent_reg      <= sent_next;
            dropped_reg   <= dropped_next;
            delivered_reg <= delivered_next;
            timeout_reg   <= timeout_next;
            seq_reg       <= seq_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            mean_reg      <= mean_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload and mean direction need no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        down_reg <= down_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

// ===== rtl/core/link_latency_statistics.sv =====
// ----------------------------------------------------------------------------
// link_latency_statistics
// Running count, minimum, maximum and mean of link latency from delivery
// reports and timeout events.
// ----------------------------------------------------------------------------
// Usage:
//   report : sink channel, one request per delivery report or timeout event
//   result : source channel, one statistics snapshot per request, in order
// Each request passes a classifying front end into a two-entry queue; the
// back end applies requests one at a time and registers the snapshot.
// Timeouts, dropped reports and first deliveries go from acceptance straight
// to the emit state; later deliveries first pass the divide state, where the
// serial divider of the mean step resolves one quotient bit per cycle.
// The back end takes a new request from the queue only when idle, so a
// request is not applied before the previous snapshot is registered.
// Reset clears every counter and statistic and empties queue and output; no
// clearing pass is needed. A stalled receiver holds the snapshot in the output
// register; the back end then waits, the queue fills and report.ready falls.
// ----------------------------------------------------------------------------
module link_latency_statistics #(
    parameter int COUNT_BITS         = 32,
    parameter int LATENCY_BITS       = 32,
    parameter int MEAN_FRACTION_BITS = 16
) (
    input logic          clk,
    input logic          rst_n,
    lls_stream_if.sink   report,
    lls_stream_if.source result
);
    lls_stream_if #(.payload_t(lls_pkg::entry_t)) front_q ();
    lls_stream_if #(.payload_t(lls_pkg::entry_t)) q_back ();

    // classify
    lls_front #(
        .LATENCY_BITS (LATENCY_BITS)
    ) u_front (
        .report (report),
        .entry  (front_q.source)
    );

    // decoupling queue
    lls_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_q.sink),
        .pop   (q_back.source)
    );

    // execute
    lls_back #(
        .COUNT_BITS         (COUNT_BITS),
        .LATENCY_BITS       (LATENCY_BITS),
        .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .queue  (q_back.sink),
        .result (result)
    );

    // no delivery yet: latency statistics stay cleared
    a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.payload.stats_valid |->
            result.payload.latency_min == 32'd0 &&
            result.payload.latency_max == 32'd0 &&
            result.payload.latency_mean == 48'd0)
        else $error("latency statistics set before any delivery");

    // mean stays between minimum and maximum
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.stats_valid |->
            result.payload.latency_mean <=
                (48'(result.payload.latency_max) << MEAN_FRACTION_BITS) &&
            result.payload.latency_mean >=
                (48'(result.payload.latency_min) << MEAN_FRACTION_BITS))
        else $error("running mean outside latency range");

endmodule
